### rtl/tcm_pkg.sv
`default_nettype none
package tcm_pkg;

    localparam int MSG_CAP_DEF      = 32;
    localparam int NUM_TRIGGERS_DEF = 8;

    localparam int BYTE_W = 8;
    localparam int KIND_W = 2;
    localparam int MASK_W = 8;

    localparam logic [BYTE_W-1:0] TERM_RESET = 8'd10;

    typedef enum logic [KIND_W-1:0] {
        KIND_RX_BYTE   = 2'd0,
        KIND_LOAD_BYTE = 2'd1,
        KIND_CLR_TRIG  = 2'd2,
        KIND_CLR_MSG   = 2'd3
    } t_kind;

    // per-cycle commands broadcast from the controller to every cell
    typedef struct packed {
        logic              rx_byte;   // data byte compared at the receive position
        logic              rx_term;   // message closed, result taken this cycle
        logic              rx_ovf;    // data byte dropped, message overflowed
        logic              ld_wr;     // trigger byte written at the load position
        logic              ld_close;  // trigger closed by a terminator
        logic              clr_trig;  // whole trigger table cleared
        logic              clr_msg;   // message restarted without result
        logic [BYTE_W-1:0] data;
    } t_cell_ctrl;

endpackage
`default_nettype wire

### rtl/tcm_cell.sv
`default_nettype none
module tcm_cell #(
    parameter int MSG_CAP  = tcm_pkg::MSG_CAP_DEF,
    parameter bit IS_FIRST = 1'b0
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire  tcm_pkg::t_cell_ctrl      i_ctrl,
    input  wire  [$clog2(MSG_CAP)-1:0]     i_rx_pos,
    input  wire  [$clog2(MSG_CAP)-1:0]     i_rd_addr,
    input  wire  [$clog2(MSG_CAP)-1:0]     i_load_pos,
    input  wire                            i_token,
    output logic                           o_armed,
    output logic                           o_hit
);

    localparam int LW = $clog2(MSG_CAP + 1);

    logic [tcm_pkg::BYTE_W-1:0] r_mem [MSG_CAP];
    logic [tcm_pkg::BYTE_W-1:0] r_rd;
    logic [LW-1:0]              r_len;
    logic [LW-1:0]              n_len;
    logic                       r_match;
    logic                       n_match;
    logic                       r_armed;
    logic                       n_armed;
    logic                       wr_en;
    logic [LW-1:0]              rx_pos_ext;
    logic [LW-1:0]              rx_next_ext;

    assign wr_en       = i_ctrl.ld_wr & r_armed;
    assign rx_pos_ext  = LW'(i_rx_pos);
    assign rx_next_ext = rx_pos_ext + LW'(1);

    // trigger bytes; read ahead at the next receive position, write-first
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[i_load_pos] <= i_ctrl.data;
        end
        if (wr_en && (i_load_pos == i_rd_addr)) begin
            r_rd <= i_ctrl.data;
        end else begin
            r_rd <= r_mem[i_rd_addr];
        end
    end

    always_comb begin
        n_armed = r_armed;
        if (i_ctrl.clr_trig) begin
            n_armed = IS_FIRST;
        end else if (i_ctrl.ld_close && r_armed) begin
            n_armed = 1'b0;
        end else if (i_token) begin
            n_armed = 1'b1;
        end
    end

    always_comb begin
        n_len = r_len;
        if (i_ctrl.clr_trig) begin
            n_len = '0;
        end else if (i_ctrl.ld_close && r_armed) begin
            n_len = LW'(i_load_pos) + LW'(1);
        end
    end

    always_comb begin
        n_match = r_match;
        if (i_ctrl.clr_msg || i_ctrl.rx_term) begin
            n_match = 1'b1;
        end else if (i_ctrl.rx_ovf) begin
            n_match = 1'b0;
        end else if (i_ctrl.rx_byte) begin
            n_match = r_match & (rx_next_ext < r_len) & (r_rd == i_ctrl.data);
        end else if (i_ctrl.clr_trig) begin
            n_match = (i_rx_pos == '0);
        end else if (i_ctrl.ld_close && r_armed && (i_rx_pos != '0)) begin
            // a message already holding data cannot match a new trigger
            n_match = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed <= IS_FIRST;
            r_len   <= '0;
            r_match <= 1'b1;
        end else begin
            r_armed <= n_armed;
            r_len   <= n_len;
            r_match <= n_match;
        end
    end

    assign o_armed = r_armed;
    assign o_hit   = r_match & (rx_pos_ext < r_len);

endmodule
`default_nettype wire

### rtl/terminated_command_matcher_core.sv
`default_nettype none
// Channel   | Direction | Signals                              | Contents (low bit up)
// s_axis    | in        | tvalid tready tdata[7:0] tuser[1:0]  | tdata: byte_value; tuser: kind
// m_axis    | out       | tvalid tready tdata[7:0] tuser[0:0]  | tdata: match_mask; tuser: overflow
// cfg       | in        | valid ready data[7:0]                | terminator byte
//
// One item is taken every cycle while s_axis tready is high; each cell compares its
// trigger byte against the incoming byte in the same cycle, read ahead from its own small memory.
// A terminator's result is registered; it shows on m_axis the cycle after the item if m_axis is free.
// Reset is synchronous and active low; the trigger bytes themselves are not cleared.
// The output holds a register and a skid entry; s_axis tready drops only when both wait.
module terminated_command_matcher_core #(
    parameter int MSG_CAP      = tcm_pkg::MSG_CAP_DEF,
    parameter int NUM_TRIGGERS = tcm_pkg::NUM_TRIGGERS_DEF
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  wire  [tcm_pkg::BYTE_W-1:0]        i_s_axis_tdata,  // [7:0] byte_value
    input  wire  [tcm_pkg::KIND_W-1:0]        i_s_axis_tuser,  // [1:0] kind
    output logic                              o_m_axis_tvalid,
    input  wire                               i_m_axis_tready,
    output logic [tcm_pkg::MASK_W-1:0]        o_m_axis_tdata,  // [7:0] match_mask
    output logic [0:0]                        o_m_axis_tuser,  // [0] overflow
    input  wire                               i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire  [tcm_pkg::BYTE_W-1:0]        i_cfg_data
);

    localparam int PW = $clog2(MSG_CAP);
    localparam logic [PW-1:0] POS_LAST = PW'(MSG_CAP - 1);

    typedef logic [tcm_pkg::MASK_W:0] t_result;  // {overflow, match_mask}

    logic [tcm_pkg::BYTE_W-1:0] r_term;
    logic [PW-1:0]              r_rx_pos;
    logic [PW-1:0]              n_rx_pos;
    logic [PW-1:0]              r_load_pos;
    logic [PW-1:0]              n_load_pos;
    logic                       r_ovf_seen;
    logic                       n_ovf_seen;
    logic                       r_out_valid;
    logic                       r_skid_valid;
    t_result                    r_out;
    t_result                    r_skid;
    t_result                    res;

    tcm_pkg::t_kind             kind;
    tcm_pkg::t_cell_ctrl        ctrl;
    logic                       acc;
    logic                       is_term;
    logic                       table_full;
    logic                       push;
    logic                       pop;
    logic [NUM_TRIGGERS-1:0]    armed;
    logic [NUM_TRIGGERS-1:0]    hit;
    logic [tcm_pkg::MASK_W-1:0] mask;

    assign kind       = tcm_pkg::t_kind'(i_s_axis_tuser);
    assign acc        = i_s_axis_tvalid & o_s_axis_tready;
    assign is_term    = (i_s_axis_tdata == r_term);
    assign table_full = ~|armed;

    always_comb begin
        ctrl          = '0;
        ctrl.data     = i_s_axis_tdata;
        if (acc) begin
            case (kind)
                tcm_pkg::KIND_RX_BYTE: begin
                    ctrl.rx_term = is_term;
                    ctrl.rx_ovf  = !is_term && (r_rx_pos == POS_LAST);
                    ctrl.rx_byte = !is_term && (r_rx_pos != POS_LAST);
                end
                tcm_pkg::KIND_LOAD_BYTE: begin
                    ctrl.ld_close = !table_full && is_term;
                    ctrl.ld_wr    = !table_full && !is_term && (r_load_pos != POS_LAST);
                end
                tcm_pkg::KIND_CLR_TRIG: begin
                    ctrl.clr_trig = 1'b1;
                end
                tcm_pkg::KIND_CLR_MSG: begin
                    ctrl.clr_msg = 1'b1;
                end
                default: begin
                    ctrl.clr_msg = 1'b0;
                end
            endcase
        end
    end

    always_comb begin
        n_rx_pos   = r_rx_pos;
        n_ovf_seen = r_ovf_seen;
        if (ctrl.rx_term || ctrl.clr_msg) begin
            n_rx_pos   = '0;
            n_ovf_seen = 1'b0;
        end else if (ctrl.rx_ovf) begin
            n_ovf_seen = 1'b1;
        end else if (ctrl.rx_byte) begin
            n_rx_pos = r_rx_pos + PW'(1);
        end
    end

    always_comb begin
        n_load_pos = r_load_pos;
        if (ctrl.clr_trig || ctrl.ld_close) begin
            n_load_pos = '0;
        end else if (ctrl.ld_wr) begin
            n_load_pos = r_load_pos + PW'(1);
        end
    end

    // row of trigger cells; the load token moves to the right neighbor on close
    for (genvar g = 0; g < NUM_TRIGGERS; g++) begin : g_cell
        logic token;
        if (g == 0) begin : g_head
            assign token = 1'b0;
        end else begin : g_body
            assign token = armed[g-1] & ctrl.ld_close;
        end
        tcm_cell #(
            .MSG_CAP  (MSG_CAP),
            .IS_FIRST (g == 0)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctrl     (ctrl),
            .i_rx_pos   (r_rx_pos),
            .i_rd_addr  (n_rx_pos),
            .i_load_pos (r_load_pos),
            .i_token    (token),
            .o_armed    (armed[g]),
            .o_hit      (hit[g])
        );
    end

    for (genvar b = 0; b < tcm_pkg::MASK_W; b++) begin : g_mask
        if (b < NUM_TRIGGERS) begin : g_used
            assign mask[b] = hit[b];
        end else begin : g_pad
            assign mask[b] = 1'b0;
        end
    end

    assign res  = {r_ovf_seen, mask};
    assign push = ctrl.rx_term;
    assign pop  = r_out_valid & i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_term       <= tcm_pkg::TERM_RESET;
            r_rx_pos     <= '0;
            r_load_pos   <= '0;
            r_ovf_seen   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_term <= i_cfg_data;
            end
            r_rx_pos   <= n_rx_pos;
            r_load_pos <= n_load_pos;
            r_ovf_seen <= n_ovf_seen;
            if (pop) begin
                if (r_skid_valid) begin
                    r_skid_valid <= push;
                end else begin
                    r_out_valid <= push;
                end
            end else if (push) begin
                if (r_out_valid) begin
                    r_skid_valid <= 1'b1;
                end else begin
                    r_out_valid <= 1'b1;
                end
            end
        end
    end

    // result payload: a result enters the output or skid entry; the skid advances on an output pop
    always_ff @(posedge i_clk) begin
        if (pop && r_skid_valid) begin
            r_out <= r_skid;
        end else if (push && (!r_out_valid || pop)) begin
            r_out <= res;
        end
        if (push && (r_out_valid && !(pop && !r_skid_valid))) begin
            r_skid <= res;
        end
    end

    assign o_s_axis_tready = !r_skid_valid;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out[tcm_pkg::MASK_W-1:0];
    assign o_m_axis_tuser  = r_out[tcm_pkg::MASK_W];
    assign o_cfg_ready     = 1'b1;

endmodule
`default_nettype wire
